FILE: hdl/phb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phb_pkg
// Shared types and constants of the binned pixel histogram engine.
// ----------------------------------------------------------------------------
package phb_pkg;

    localparam int PIXEL_BITS  = 16;
    localparam int COUNT_BITS  = 32;
    localparam int FIELD_BITS  = 16;
    localparam int OUT_BITS    = 32;
    localparam int NARROW_BINS = 256;
    localparam int SHIFT_BITS  = 4;
    localparam int STORE_DEPTH = 1 << PIXEL_BITS;
    localparam int USED_BITS   = PIXEL_BITS + 1;
    localparam int CMP_BITS    = FIELD_BITS + 1;
    localparam int SAT_BITS    = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = SHIFT_BITS;

    typedef enum logic [1:0] {
        KIND_COUNT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BIN_SHIFT   = 1'd0,
        REG_WIDE_PIXELS = 1'd1
    } t_reg;

    typedef struct packed {
        logic                  out_of_range;
        logic [FIELD_BITS-1:0] bin_echo;
        logic [OUT_BITS-1:0]   bin_count;
    } t_result;

endpackage : phb_pkg
`default_nettype wire

FILE: hdl/pixel_histogram_binned.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_histogram_binned
// Counts pixels into bins held in one synchronous memory and answers reads.
// ----------------------------------------------------------------------------
// Pixel items are taken at one per cycle while the input does not stall: a
// pixel reads its bin in the cycle it is accepted, and the next cycle adds
// one and writes it back, with the last write forwarded so that repeated bins
// count correctly. Read items also pass at one per cycle while the result sink
// keeps up; results wait in a two-entry output queue, and the input stalls
// once that queue and the read in flight would fill it. After reset and after
// every clear item the block sweeps the whole store, one bin per cycle, and
// accepts no item during the sweep.
module pixel_histogram_binned (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [phb_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire [phb_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // pixel_value [15:0], bin_number [31:16]
    input  wire [2*phb_pkg::FIELD_BITS-1:0]    s_axis_tdata,
    // kind [1:0]
    input  wire [1:0]                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // bin_count [31:0], bin_echo [47:32]
    output logic [phb_pkg::OUT_BITS+phb_pkg::FIELD_BITS-1:0] m_axis_tdata,
    // out_of_range [0]
    output logic                               m_axis_tuser
);

    localparam int PB = phb_pkg::PIXEL_BITS;
    localparam int CB = phb_pkg::COUNT_BITS;

    logic [CB-1:0] r_mem [phb_pkg::STORE_DEPTH];

    logic [phb_pkg::SHIFT_BITS-1:0] r_bin_shift;
    logic                           r_wide;
    logic                           r_clearing, n_clearing;
    logic [PB-1:0]                  r_clr_ptr, n_clr_ptr;

    logic                           r_s1_valid;
    phb_pkg::t_kind                 r_s1_kind;
    logic                           r_s1_hit;
    logic                           r_s1_oor;
    logic [PB-1:0]                  r_s1_addr;
    logic [phb_pkg::FIELD_BITS-1:0] r_s1_bin;
    logic [CB-1:0]                  r_rd_data;

    logic                           r_fw_valid;
    logic [PB-1:0]                  r_fw_addr;
    logic [CB-1:0]                  r_fw_data;

    phb_pkg::t_result               r_q [2];
    logic                           r_q_wr, r_q_rd;
    logic [1:0]                     r_q_cnt;

    phb_pkg::t_kind                 in_kind;
    logic [phb_pkg::FIELD_BITS-1:0] in_pixel, in_bin;
    logic                           accept, push, pop;
    logic [PB-1:0]                  pix_m, pix_idx, rd_addr;
    logic [phb_pkg::USED_BITS-1:0]  used;
    logic                           pix_hit, bin_oor;
    logic [CB-1:0]                  cur, inc;
    logic                           wr_en;
    logic [PB-1:0]                  wr_addr;
    logic [CB-1:0]                  wr_data;
    logic [phb_pkg::SAT_BITS-1:0]   cur_ext;
    phb_pkg::t_result               res;
    logic [2:0]                     occ_next;

    assign in_kind  = phb_pkg::t_kind'(s_axis_tuser);
    assign in_pixel = s_axis_tdata[phb_pkg::FIELD_BITS-1:0];
    assign in_bin   = s_axis_tdata[2*phb_pkg::FIELD_BITS-1:phb_pkg::FIELD_BITS];

    assign push     = r_s1_valid && (r_s1_kind == phb_pkg::KIND_READ);
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign occ_next = 3'(r_q_cnt) + 3'(push) - 3'(pop);
    assign s_axis_tready = !r_clearing && (occ_next < 3'd2);
    assign accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        pix_m = r_wide ? in_pixel[PB-1:0] : PB'(in_pixel[7:0]);
        pix_idx = pix_m >> r_bin_shift;
        used = (r_wide ? (phb_pkg::USED_BITS'(1) << PB)
                       : phb_pkg::USED_BITS'(phb_pkg::NARROW_BINS)) >> r_bin_shift;
        pix_hit = {1'b0, pix_idx} < used;
        bin_oor = !({1'b0, in_bin} < phb_pkg::CMP_BITS'(used));
        rd_addr = (in_kind == phb_pkg::KIND_READ) ? in_bin[PB-1:0] : pix_idx;
    end

    always_comb begin
        cur = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data;
        inc = (cur == {CB{1'b1}}) ? cur : cur + CB'(1);
        wr_en   = r_clearing || (r_s1_valid && r_s1_hit);
        wr_addr = r_clearing ? r_clr_ptr : r_s1_addr;
        wr_data = r_clearing ? '0 : inc;
        cur_ext = phb_pkg::SAT_BITS'(cur);
        res.out_of_range = r_s1_oor;
        res.bin_echo     = r_s1_bin;
        if (r_s1_oor) begin
            res.bin_count = '0;
        end else if (cur_ext > phb_pkg::SAT_BITS'({phb_pkg::OUT_BITS{1'b1}})) begin
            res.bin_count = {phb_pkg::OUT_BITS{1'b1}};
        end else begin
            res.bin_count = cur_ext[phb_pkg::OUT_BITS-1:0];
        end
    end

    always_comb begin
        n_clearing = r_clearing;
        n_clr_ptr  = r_clr_ptr;
        if (r_clearing) begin
            n_clr_ptr = r_clr_ptr + PB'(1);
            if (r_clr_ptr == {PB{1'b1}}) begin
                n_clearing = 1'b0;
            end
        end else if (accept && (in_kind == phb_pkg::KIND_CLEAR)) begin
            n_clearing = 1'b1;
            n_clr_ptr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_shift <= '0;
            r_wide      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (phb_pkg::t_reg'(i_cfg_index))
                phb_pkg::REG_BIN_SHIFT:   r_bin_shift <= i_cfg_data[phb_pkg::SHIFT_BITS-1:0];
                phb_pkg::REG_WIDE_PIXELS: r_wide      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_ptr  <= '0;
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_q_wr     <= 1'b0;
            r_q_rd     <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_ptr  <= n_clr_ptr;
            r_s1_valid <= accept;
            if (wr_en) begin
                r_fw_valid <= 1'b1;
            end
            if (push) begin
                r_q_wr <= !r_q_wr;
            end
            if (pop) begin
                r_q_rd <= !r_q_rd;
            end
            r_q_cnt <= r_q_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= in_kind;
            r_s1_hit  <= (in_kind == phb_pkg::KIND_COUNT) && pix_hit;
            r_s1_oor  <= bin_oor;
            r_s1_addr <= rd_addr;
            r_s1_bin  <= in_bin;
        end
        if (wr_en) begin
            r_fw_addr <= wr_addr;
            r_fw_data <= wr_data;
        end
        if (push) begin
            r_q[r_q_wr] <= res;
        end
    end

    assign m_axis_tvalid = (r_q_cnt != 2'd0);
    assign m_axis_tdata  = {r_q[r_q_rd].bin_echo, r_q[r_q_rd].bin_count};
    assign m_axis_tuser  = r_q[r_q_rd].out_of_range;

endmodule : pixel_histogram_binned
`default_nettype wire

FILE: hdl/phb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phb_checker
// Port-level checks of the binned pixel histogram engine.
// ----------------------------------------------------------------------------
module phb_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire [1:0]                          s_axis_tuser,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("Input ready right after reset.");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tuser == phb_pkg::KIND_CLEAR) |=> !s_axis_tready)
        else $error("Input ready right after a clear item.");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (s_axis_tuser == phb_pkg::KIND_READ) |=> ##1 m_axis_tvalid)
        else $error("No result two cycles after a read item.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result withdrawn before it was taken.");

endmodule : phb_checker

bind pixel_histogram_binned phb_checker u_phb_checker (.*);
`default_nettype wire

FILE: bench/pixel_histogram_binned_checker.sv
// ----------------------------------------------------------------------------
// pixel_histogram_binned_checker
// Watches the register port and both streams of the histogram engine, keeps
// its own copy of the bin counters and settings, and compares every returned
// read result field by field with the oldest outstanding read.
// ----------------------------------------------------------------------------
module pixel_histogram_binned_checker
    import phb_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]        i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]       i_cfg_data,
    input  wire                           s_axis_tvalid,
    input  wire                           s_axis_tready,
    // pixel_value [15:0], bin_number [31:16]
    input  wire [2*FIELD_BITS-1:0]        s_axis_tdata,
    // kind [1:0]
    input  wire [1:0]                     s_axis_tuser,
    input  wire                           m_axis_tvalid,
    input  wire                           m_axis_tready,
    // bin_count [31:0], bin_echo [47:32]
    input  wire [OUT_BITS+FIELD_BITS-1:0] m_axis_tdata,
    // out_of_range [0]
    input  wire                           m_axis_tuser,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results
);

    logic [COUNT_BITS-1:0] tally [STORE_DEPTH];
    logic [SHIFT_BITS-1:0] shift_q;
    logic                  wide_q;
    t_result               reads_due [$];

    function automatic int unsigned bins_used();
        return (wide_q ? STORE_DEPTH : NARROW_BINS) >> shift_q;
    endfunction

    task automatic count_pixel(input logic [FIELD_BITS-1:0] pixel);
        logic [FIELD_BITS-1:0] masked;
        int unsigned           bin;
        masked = wide_q ? pixel : {8'h00, pixel[7:0]};
        bin    = masked >> shift_q;
        if (bin < bins_used() && tally[bin] != {COUNT_BITS{1'b1}}) begin
            tally[bin] = tally[bin] + 1'b1;
        end
    endtask

    function automatic t_result answer_read(input logic [FIELD_BITS-1:0] bin);
        t_result             r;
        logic [SAT_BITS-1:0] c;
        r.out_of_range = !(bin < bins_used());
        r.bin_echo     = bin;
        c = r.out_of_range ? '0 : SAT_BITS'(tally[bin]);
        r.bin_count = (c > SAT_BITS'({OUT_BITS{1'b1}})) ? '1 : c[OUT_BITS-1:0];
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            foreach (tally[i]) tally[i] = '0;
            shift_q = '0;
            wide_q  = 1'b0;
            reads_due.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BIN_SHIFT:   shift_q = i_cfg_data;
                    REG_WIDE_PIXELS: wide_q  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.bin_count    = m_axis_tdata[OUT_BITS-1:0];
                got.bin_echo     = m_axis_tdata[OUT_BITS+FIELD_BITS-1:OUT_BITS];
                got.out_of_range = m_axis_tuser;
                o_results++;
                if (reads_due.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result, expected none, actual bin %0h count %0h",
                             $time, got.bin_echo, got.bin_count);
                end else begin
                    want = reads_due.pop_front();
                    compare_field("bin_count", want.bin_count, got.bin_count);
                    compare_field("bin_echo", want.bin_echo, got.bin_echo);
                    compare_field("out_of_range", want.out_of_range, got.out_of_range);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    KIND_COUNT: count_pixel(s_axis_tdata[FIELD_BITS-1:0]);
                    KIND_READ:  reads_due = {reads_due,
                                    answer_read(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS])};
                    KIND_CLEAR: foreach (tally[i]) tally[i] = '0;
                    default: ;
                endcase
            end
            o_pending = reads_due.size();
        end
    end

endmodule

FILE: bench/pixel_histogram_binned_test.sv
// ----------------------------------------------------------------------------
// pixel_histogram_binned_test
// Drives the histogram engine with directed and random pixel, read, clear and
// unused-kind items across many bin shift and pixel width settings, with
// random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module pixel_histogram_binned_test;
    import phb_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         QUIET_LIMIT = 200000;
    localparam int         RANDOM_ITEMS = 1000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [CFG_IDX_BITS-1:0]        i_cfg_index;
    logic [CFG_DATA_BITS-1:0]       i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [2*FIELD_BITS-1:0]        s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [OUT_BITS+FIELD_BITS-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    int errors;
    int pending;
    int results;

    bit                    calm;
    logic [SHIFT_BITS-1:0] cur_shift;
    bit                    cur_wide;
    logic [FIELD_BITS-1:0] hot [8];
    int unsigned           n_count, n_read, n_clear, n_unused, n_settings;
    int unsigned           clears_left = 4;
    int                    quiet;

    logic [SHIFT_BITS-1:0] shift_plan [7] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd8, 4'd9, 4'd7};
    bit                    wide_plan  [7] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    pixel_histogram_binned u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pixel_histogram_binned_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_results     (results)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : result_sink
        int hold;
        bit held;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results >= 150) begin
                held = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    task automatic push_item(input logic [1:0] kind, input logic [FIELD_BITS-1:0] pixel,
                             input logic [FIELD_BITS-1:0] bin);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bin, pixel};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        case (kind)
            KIND_COUNT: n_count++;
            KIND_READ:  n_read++;
            KIND_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
    endtask

    task automatic settle(input int cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [SHIFT_BITS-1:0] shift, input bit wide);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_BIN_SHIFT;
        i_cfg_data  <= shift;
        @(negedge i_clk);
        i_cfg_index <= REG_WIDE_PIXELS;
        i_cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, wide};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_shift  = shift;
        cur_wide   = wide;
        n_settings++;
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_pixel();
        if ($urandom_range(99) < 70) return hot[$urandom_range(7)];
        return FIELD_BITS'($urandom);
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_bin();
        int unsigned           used;
        int unsigned           pick;
        logic [FIELD_BITS-1:0] h;
        used = (cur_wide ? STORE_DEPTH : NARROW_BINS) >> cur_shift;
        pick = $urandom_range(99);
        h    = hot[$urandom_range(7)];
        if (pick < 50) return FIELD_BITS'((cur_wide ? h : {8'h00, h[7:0]}) >> cur_shift);
        if (pick < 70 && used > 0) return FIELD_BITS'($urandom_range(used - 1));
        if (pick < 85) return FIELD_BITS'($urandom);
        return FIELD_BITS'(used + $urandom_range(2) - 1);
    endfunction

    task automatic random_item(input bit clears_allowed);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 56) begin
            push_item(KIND_COUNT, pick_pixel(), FIELD_BITS'($urandom));
        end else if (pick < 93) begin
            push_item(KIND_READ, FIELD_BITS'($urandom), pick_bin());
        end else if (pick < 98 || !clears_allowed || clears_left == 0) begin
            push_item(KIND_UNUSED, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
        end else begin
            clears_left--;
            push_item(KIND_CLEAR, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned length;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_BIN_SHIFT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_COUNT;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Narrow pixels use only their low byte; reads past the last bin are flagged.
        write_config(4'd0, 1'b0);
        push_item(KIND_COUNT, 16'h0000, 16'hFFFF);
        push_item(KIND_COUNT, 16'hFFFF, 16'h0000);
        push_item(KIND_COUNT, 16'hFF00, 16'h0000);
        push_item(KIND_COUNT, 16'h00FF, 16'h0000);
        push_item(KIND_COUNT, 16'h00FF, 16'h0000);
        push_item(KIND_UNUSED, 16'hFFFF, 16'h0000);
        push_item(KIND_READ, 16'hFFFF, 16'h0000);
        push_item(KIND_READ, 16'h0000, 16'h00FF);
        push_item(KIND_READ, 16'h0000, 16'h0100);
        push_item(KIND_READ, 16'h0000, 16'hFFFF);
        push_item(KIND_READ, 16'h0000, 16'h8000);

        // With a shift above eight in narrow mode no bin is in use.
        settle(8);
        write_config(4'd9, 1'b0);
        push_item(KIND_COUNT, 16'h1234, 16'h0000);
        push_item(KIND_READ, 16'h0000, 16'h0000);

        // Counters survive a mode change; only a clear empties them.
        settle(8);
        write_config(4'd15, 1'b1);
        push_item(KIND_COUNT, 16'hFFFF, 16'h0000);
        push_item(KIND_COUNT, 16'h7FFF, 16'h0000);
        push_item(KIND_READ, 16'h0000, 16'h0001);
        push_item(KIND_READ, 16'h0000, 16'h0002);
        push_item(KIND_READ, 16'h0000, 16'h0000);
        push_item(KIND_CLEAR, 16'h0000, 16'h0000);
        push_item(KIND_READ, 16'h0000, 16'h0001);

        phase = 0;
        while (n_count + n_read + n_clear < RANDOM_ITEMS + 20) begin
            settle(8);
            if (phase < 7) begin
                write_config(shift_plan[phase], wide_plan[phase]);
            end else begin
                write_config(SHIFT_BITS'($urandom_range(15)), bit'($urandom_range(1)));
            end
            calm = (phase == 2);
            foreach (hot[i]) hot[i] = FIELD_BITS'($urandom);
            length = $urandom_range(120, 40);
            repeat (length) random_item(phase % 2 == 1);
            push_item(KIND_READ, FIELD_BITS'($urandom), pick_bin());
            phase++;
        end
        calm = 1'b0;
        settle(20);

        $display("Ran %0d pixel, %0d read, %0d clear and %0d unused-kind items", n_count,
                 n_read, n_clear, n_unused);
        $display("over %0d register settings; %0d results compared.", n_settings, results);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
